@@ src/tms_pkg.sv @@
package tms_pkg;

    localparam int MAX_SAMPLES_DEF = 256;
    localparam int SAMPLE_W        = 16;
    localparam int COUNT_W         = 9;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd150;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_PICK_LO,
        ST_PICK_HI,
        ST_SUM,
        ST_OUT
    } tms_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture a new sample and start the insertion scan
        logic step;      // one scan step: read entry, shift or place
        logic rd_lo;     // read the lower middle entry
        logic rd_hi;     // read the upper middle entry
        logic sum;       // form the median from the read entries
        logic clear;     // group complete: restart fill count
    } tms_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic placed;    // sample written at its place this cycle
        logic complete;  // group holds enough samples
    } tms_stat_t;

endpackage

@@ src/tms_datapath.sv @@
module tms_datapath #(
    parameter int MAX_SAMPLES = tms_pkg::MAX_SAMPLES_DEF,
    parameter int PW = $clog2(MAX_SAMPLES + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [tms_pkg::SAMPLE_W-1:0]  sample,
    input  logic [tms_pkg::COUNT_W-1:0]   count_cfg,
    input  tms_pkg::tms_cmd_t             cmd,
    output tms_pkg::tms_stat_t            stat,
    output logic [tms_pkg::SAMPLE_W-1:0]  median
);
    import tms_pkg::*;

    localparam int AW = $clog2(MAX_SAMPLES);

    logic [SAMPLE_W-1:0] store [MAX_SAMPLES];
    logic [SAMPLE_W-1:0] rd_data_reg;
    logic [SAMPLE_W-1:0] lo_reg, lo_next;
    logic [SAMPLE_W-1:0] val_reg;
    logic [PW-1:0]       fill_reg, fill_next;
    logic [PW-1:0]       pos_reg, pos_next;
    logic                rd_ok_reg, rd_ok_next;
    logic [PW-1:0]       eff_count;
    logic [PW-1:0]       half;
    logic [SAMPLE_W:0]   sum;
    logic [SAMPLE_W-1:0] median_reg, median_next;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [SAMPLE_W-1:0] wr_data;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic                place;

    // Effective group size: zero counts as one, capacity caps it.
    always_comb
    begin
        if (count_cfg == '0)
            eff_count = PW'(1);
        else if (32'(count_cfg) > MAX_SAMPLES)
            eff_count = PW'(MAX_SAMPLES);
        else
            eff_count = PW'(count_cfg);
    end

    assign half = fill_reg >> 1;

    // The scan walks down from the fill position; the read data of the entry
    // below is registered and present in the cycle after its read, flagged by rd_ok.
    assign place = cmd.step && (pos_reg == '0 ||
                   (rd_ok_reg && !(rd_data_reg > val_reg)));

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = pos_reg[AW-1:0];
        wr_data = val_reg;
        rd_en   = 1'b0;
        rd_addr = AW'(pos_reg - PW'(1));
        pos_next   = pos_reg;
        rd_ok_next = 1'b0;
        fill_next  = fill_reg;
        lo_next    = lo_reg;
        median_next = median_reg;
        if (cmd.load)
        begin
            pos_next = (fill_reg >= PW'(MAX_SAMPLES)) ? PW'(MAX_SAMPLES - 1) : fill_reg;
            rd_en    = 1'b1;
            rd_addr  = AW'(pos_next - PW'(1));
            rd_ok_next = 1'b1;
        end
        else if (cmd.step)
        begin
            if (place)
            begin
                wr_en = 1'b1;
                fill_next = pos_reg == PW'(MAX_SAMPLES) ? fill_reg : fill_reg + PW'(1);
                if (fill_reg >= PW'(MAX_SAMPLES))
                    fill_next = PW'(MAX_SAMPLES);
            end
            else if (rd_ok_reg)
            begin
                // Entry below is larger: move it up one place.
                wr_en   = 1'b1;
                wr_data = rd_data_reg;
                pos_next = pos_reg - PW'(1);
                if (pos_next != '0)
                begin
                    rd_en = 1'b1;
                    rd_addr = AW'(pos_next - PW'(1));
                    rd_ok_next = 1'b1;
                end
            end
        end
        else if (cmd.rd_lo)
        begin
            rd_en   = 1'b1;
            rd_addr = fill_reg[0] ? AW'(half) : AW'(half - PW'(1));
        end
        else if (cmd.rd_hi)
        begin
            lo_next = rd_data_reg;
            rd_en   = 1'b1;
            rd_addr = AW'(half);
        end
        else if (cmd.sum)
        begin
            median_next = fill_reg[0] ? lo_reg : sum[SAMPLE_W:1];
        end
        if (cmd.clear)
            fill_next = '0;
    end

    assign sum = {1'b0, lo_reg} + {1'b0, rd_data_reg};

    // Sorted store: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            store[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= store[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            val_reg <= sample;
        lo_reg     <= lo_next;
        median_reg <= median_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            pos_reg   <= '0;
            rd_ok_reg <= 1'b0;
        end
        else
        begin
            fill_reg  <= fill_next;
            pos_reg   <= pos_next;
            rd_ok_reg <= rd_ok_next;
        end
    end

    assign stat.placed   = place;
    assign stat.complete = fill_reg >= eff_count;
    assign median        = median_reg;

`ifndef SYNTH
    // The fill count never exceeds the store's capacity.
    a_fill_cap: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= PW'(MAX_SAMPLES)) else $error("fill count above capacity");
    // Placing a sample grows the group by one unless it is cleared or the store is full.
    a_fill_grow: assert property (@(posedge clk) disable iff (!rst_n)
        place && !cmd.clear && fill_reg < PW'(MAX_SAMPLES) |=> fill_reg == $past(fill_reg) + PW'(1))
        else $error("fill count did not advance");
    // During a scan step the scan position never lies above the fill count.
    a_pos: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> pos_reg <= fill_reg) else $error("scan position out of range");
`endif
endmodule

@@ src/tms_ctrl.sv @@
module tms_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  tms_pkg::tms_stat_t stat,
    output tms_pkg::tms_cmd_t  cmd
);
    import tms_pkg::*;

    tms_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Sequence: take a sample, scan it into place, then on a full group
    // read the middle pair, form the median and hold it until taken.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT:
            begin
                cmd.step = 1'b1;
                if (stat.placed)
                    state_next = ST_PICK_LO;
            end
            ST_PICK_LO:
            begin
                if (stat.complete)
                begin
                    cmd.rd_lo  = 1'b1;
                    state_next = ST_PICK_HI;
                end
                else
                    state_next = ST_IDLE;
            end
            ST_PICK_HI:
            begin
                cmd.rd_hi  = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum    = 1'b1;
                cmd.clear  = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                m_tvalid = 1'b1;
                if (m_tready)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

`ifndef SYNTH
    // No sample is taken while a result waits.
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid)) else $error("input and output both open");
    // A held result stays until it is taken.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid) else $error("result dropped");
    // A result follows only from forming the median.
    a_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(cmd.sum)) else $error("result without median");
`endif
endmodule

@@ src/temporal_median_selector.sv @@
// Temporal median of depth samples, one group of samples per pixel.
//
// Input stream s_*: one 16-bit sample per request in tdata. Every
// sample_count samples (zero counts as one, capped at MAX_SAMPLES) form
// a group; the last sample of a group produces one request on m_*
// carrying the median. An odd count gives the middle sample, an even count
// the floor of the mean of the two middle samples.
// Configuration: cfg_we with cfg_data writes sample_count; write only when
// idle. Samples already held are kept.
// Operation: a sample is inserted into a sorted memory by a scan that
// moves larger entries up one place per cycle. Before the next request
// can be taken, a sample passes the accepting state, the scan, which
// shifts each larger entry and then places the sample, and a test for
// a full group. The single read port of the memory sets the pace of
// the scan. Completing a group adds reading the middle pair and forming
// the median, after which m_tvalid rises. The result is held on m_tdata
// until the receiver takes it; no new sample is accepted while it waits.
// Reset empties the group and sets sample_count to 150; the memory is
// not cleared, as only entries written in the current group are used.
module temporal_median_selector #(
    parameter int MAX_SAMPLES = tms_pkg::MAX_SAMPLES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] sample
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] median
    input  logic        cfg_we,
    input  logic [8:0]  cfg_data
);
    import tms_pkg::*;

    logic [COUNT_W-1:0] count_reg;
    tms_cmd_t           cmd;
    tms_stat_t          stat;

    // Group size register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= COUNT_RESET;
        else if (cfg_we)
            count_reg <= cfg_data;
    end

    tms_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tms_datapath #(.MAX_SAMPLES(MAX_SAMPLES)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (s_tdata),
        .count_cfg (count_reg),
        .cmd       (cmd),
        .stat      (stat),
        .median    (m_tdata)
    );
endmodule
